### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk and held off during reset
`define DFMP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk and held off during reset
`define DFMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/dfmp_pkg.sv
`default_nettype none

package dfmp_pkg;

  // field widths
  localparam int KHZ_W       = 22;
  localparam int CNT_W       = 32;
  localparam int SEQ_W       = 32;
  localparam int AGE_W       = 8;
  localparam int CMD_W       = 2;
  localparam int SIG_W       = 3;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 88;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 48;

  // item kinds
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_BURST = 2'd1,
    CMD_START = 2'd2
  } cmd_t;

  // load signal codes
  localparam logic [SIG_W-1:0] SIG_SLACK    = 3'd1;
  localparam logic [SIG_W-1:0] SIG_BUSY     = 3'd2;
  localparam logic [SIG_W-1:0] SIG_SLIP     = 3'd3;
  localparam logic [SIG_W-1:0] SIG_BIG_SLIP = 3'd4;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ENABLE     = 3'd0,
    REG_REMEMBERED = 3'd1,
    REG_MIN        = 3'd2,
    REG_MAX        = 3'd3,
    REG_STEP       = 3'd4,
    REG_MIN_VOTES  = 3'd5
  } cfg_reg_t;

  localparam logic [KHZ_W-1:0] STEP_RESET       = 22'd100000;
  localparam logic [AGE_W-1:0] ARM_EXPIRY_TICKS = 8'd240;
  localparam logic [AGE_W-1:0] ARM_AGE_LIMIT    = 8'd241;
  localparam logic [AGE_W-1:0] ARM_AGE_MAX      = 8'hFF;
  localparam logic [CNT_W-1:0] CNT_MAX          = 32'hFFFF_FFFF;

  // request from the policy sequencer to the histogram walker
  typedef struct packed {
    logic             go;
    logic             clear;
    logic             vote;
    logic [KHZ_W-1:0] khz;
  } hist_req_t;

  // walker answer, done pulses for one cycle
  typedef struct packed {
    logic             done;
    logic [KHZ_W-1:0] best_khz;
  } hist_rsp_t;

endpackage

`default_nettype wire

### sv/dfmp_hist.sv
`default_nettype none

module dfmp_hist #(
  parameter int HIST_SLOTS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dfmp_pkg::hist_req_t          req,
  input  logic [dfmp_pkg::CNT_W-1:0]   min_votes,
  output dfmp_pkg::hist_rsp_t          rsp
);
  import dfmp_pkg::*;

  localparam int IDX_W = (HIST_SLOTS > 1) ? $clog2(HIST_SLOTS) : 1;
  localparam int TOT_W = CNT_W + IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HIST_SLOTS - 1);

  // slot storage
  logic [KHZ_W-1:0] freq_mem [HIST_SLOTS];
  logic [CNT_W-1:0] cnt_mem  [HIST_SLOTS];

  logic [HIST_SLOTS-1:0] slot_vld_r, slot_vld_nxt;
  logic                  rd_run_r, rd_run_nxt;
  logic [IDX_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                  p_vld_r, p_vld_nxt;
  logic [IDX_W-1:0]      p_idx_r, p_idx_nxt;
  logic                  p_slot_vld_r, p_slot_vld_nxt;
  logic [KHZ_W-1:0]      rd_freq_r;
  logic [CNT_W-1:0]      rd_cnt_r;
  logic                  vote_r, vote_nxt;
  logic [KHZ_W-1:0]      khz_r, khz_nxt;
  logic                  found_r, found_nxt;
  logic [TOT_W-1:0]      tot_r, tot_nxt;
  logic [CNT_W-1:0]      top_n_r, top_n_nxt;
  logic [KHZ_W-1:0]      top_r, top_nxt;
  logic                  fin_r, fin_nxt;

  logic [CNT_W-1:0]      cur_cnt;
  logic [CNT_W-1:0]      new_cnt;
  logic [KHZ_W-1:0]      new_freq;
  logic                  hit;

  // shared slot unit: vote match, saturating count, running total and maximum
  always_comb begin
    cur_cnt  = p_slot_vld_r ? rd_cnt_r : '0;
    hit      = p_vld_r && vote_r && !found_r &&
               ((cur_cnt == '0) || (rd_freq_r == khz_r));
    new_cnt  = (hit && (cur_cnt != CNT_MAX)) ? cur_cnt + CNT_W'(1) : cur_cnt;
    new_freq = hit ? khz_r : rd_freq_r;
  end

  // walk sequencer: read slot i while slot i-1 is processed and written back
  always_comb begin
    rd_run_nxt     = rd_run_r;
    rd_idx_nxt     = rd_idx_r;
    p_vld_nxt      = rd_run_r;
    p_idx_nxt      = rd_idx_r;
    p_slot_vld_nxt = slot_vld_r[rd_idx_r];
    slot_vld_nxt   = slot_vld_r;
    vote_nxt       = vote_r;
    khz_nxt        = khz_r;
    found_nxt      = found_r;
    tot_nxt        = tot_r;
    top_n_nxt      = top_n_r;
    top_nxt        = top_r;
    fin_nxt        = p_vld_r && (p_idx_r == LAST_IDX);

    if (rd_run_r) begin
      if (rd_idx_r == LAST_IDX) begin
        rd_run_nxt = 1'b0;
      end else begin
        rd_idx_nxt = rd_idx_r + IDX_W'(1);
      end
    end

    if (p_vld_r) begin
      tot_nxt = tot_r + TOT_W'(new_cnt);
      // strict compare keeps the first slot on a tie
      if (new_cnt > top_n_r) begin
        top_n_nxt = new_cnt;
        top_nxt   = new_freq;
      end
      if (hit) begin
        found_nxt             = 1'b1;
        slot_vld_nxt[p_idx_r] = 1'b1;
      end
    end

    if (req.go) begin
      rd_run_nxt = 1'b1;
      rd_idx_nxt = '0;
      vote_nxt   = req.vote;
      khz_nxt    = req.khz;
      found_nxt  = 1'b0;
      tot_nxt    = '0;
      top_n_nxt  = '0;
      top_nxt    = '0;
      if (req.clear) begin
        slot_vld_nxt = '0;
      end
    end
  end

  // slot memory, one write and one read port, registered read
  always_ff @(posedge clk) begin
    if (hit) begin
      freq_mem[p_idx_r] <= new_freq;
      cnt_mem[p_idx_r]  <= new_cnt;
    end
    rd_freq_r <= freq_mem[rd_idx_r];
    rd_cnt_r  <= cnt_mem[rd_idx_r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
      rd_run_r   <= 1'b0;
      p_vld_r    <= 1'b0;
      fin_r      <= 1'b0;
    end else begin
      slot_vld_r <= slot_vld_nxt;
      rd_run_r   <= rd_run_nxt;
      p_vld_r    <= p_vld_nxt;
      fin_r      <= fin_nxt;
    end
  end

  // walk payload
  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    p_idx_r      <= p_idx_nxt;
    p_slot_vld_r <= p_slot_vld_nxt;
    vote_r       <= vote_nxt;
    khz_r        <= khz_nxt;
    found_r      <= found_nxt;
    tot_r        <= tot_nxt;
    top_n_r      <= top_n_nxt;
    top_r        <= top_nxt;
  end

  // best frequency, suppressed while too few votes
  assign rsp.done     = fin_r;
  assign rsp.best_khz = (tot_r < TOT_W'(min_votes)) ? '0 : top_r;

endmodule

`default_nettype wire

### sv/dvfs_floor_memory_policy.sv
`default_nettype none
// Frequency-governor floor memory.
// Input channel in_*: one transfer per governor event; in_tuser carries the
// kind (tick, burst, start session), in_tdata the load signal, rate sequence
// number and ceiling frequencies. Each input transfer gives exactly one
// result transfer on out_*: the tick event flags, the armed target and the
// most-voted frequency of the vote histogram.
// Configuration: cfg_wr_en writes cfg_wr_data into register cfg_addr
// (enable, remembered, min, max, step, min_votes); min_votes applies to the
// next result, the others from the next start item on. Writes are to be made
// only while the block is idle; the block itself does not enforce this.
// Timing: after the input transfer the item is evaluated, then the shared slot
// unit walks the vote histogram memory, one slot per cycle, and the result is
// loaded into the output register. in_tready is high only while no item is in
// work, so the block takes a new item only once the last result has been
// loaded into the output register.
// A finished result sits in the output register; if the receiver stalls,
// the block holds the next result until the output register is free.
// Reset (rst_n low, synchronous) empties the histogram, disarms the ladder
// and sets the configuration registers to their reset values.

`include "assert_macros.svh"

module dvfs_floor_memory_policy #(
  parameter int HIST_SLOTS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // low bit up: load signal[2:0], fast-forward flag, publication number[31:0],
  // ceiling before tick[21:0], ceiling after tick[21:0], arm cancel flag,
  // zero fill
  input  logic [dfmp_pkg::IN_TDATA_W-1:0]   in_tdata,
  // low bit up: cmd[1:0]
  input  logic [dfmp_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // low bit up: expired, slip_disarmed, target_reached, preload_dwell,
  // armed_khz[21:0], best_khz[21:0]
  output logic [dfmp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_wr_en,
  input  logic [dfmp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [dfmp_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
  import dfmp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_WALK = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic             enable_r;
  logic [KHZ_W-1:0] remembered_r;
  logic [KHZ_W-1:0] min_r;
  logic [KHZ_W-1:0] max_r;
  logic [KHZ_W-1:0] step_r;
  logic [CNT_W-1:0] min_votes_r;

  // captured input item
  logic [CMD_W-1:0] cmd_r;
  logic [SIG_W-1:0] sig_r;
  logic             ff_r;
  logic [SEQ_W-1:0] seq_r;
  logic [KHZ_W-1:0] cb_r;
  logic [KHZ_W-1:0] ca_r;
  logic             cancel_r;

  // policy state
  logic             active_r, active_nxt;
  logic             wd_r, wd_nxt;
  logic [KHZ_W-1:0] arm_r, arm_nxt;
  logic [AGE_W-1:0] age_r, age_nxt;
  logic [SEQ_W-1:0] last_vote_r, last_vote_nxt;
  logic [SEQ_W-1:0] last_ladder_r, last_ladder_nxt;

  // event flags of the current item
  logic exp_r, exp_nxt;
  logic slip_r, slip_nxt;
  logic reach_r, reach_nxt;
  logic dwell_r, dwell_nxt;

  logic [KHZ_W-1:0]       best_r, best_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic             in_xfer;
  logic             out_free;
  logic             load_out;
  logic [KHZ_W-1:0] load_best;
  logic             start_active;
  logic [KHZ_W:0]   target_sum;
  logic             wd_tick;
  logic             vote;
  logic             clear;
  hist_req_t        hist_req;
  hist_rsp_t        hist_rsp;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      remembered_r <= '0;
      min_r        <= '0;
      max_r        <= '0;
      step_r       <= STEP_RESET;
      min_votes_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_ENABLE:     enable_r     <= cfg_wr_data[0];
        REG_REMEMBERED: remembered_r <= cfg_wr_data[KHZ_W-1:0];
        REG_MIN:        min_r        <= cfg_wr_data[KHZ_W-1:0];
        REG_MAX:        max_r        <= cfg_wr_data[KHZ_W-1:0];
        REG_STEP:       step_r       <= cfg_wr_data[KHZ_W-1:0];
        REG_MIN_VOTES:  min_votes_r  <= cfg_wr_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // capture the item on its input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r    <= in_tuser[1:0];
      sig_r    <= in_tdata[2:0];
      ff_r     <= in_tdata[3];
      seq_r    <= in_tdata[35:4];
      cb_r     <= in_tdata[57:36];
      ca_r     <= in_tdata[79:58];
      cancel_r <= in_tdata[80];
    end
  end

  // policy update, applied in the evaluate cycle
  always_comb begin
    active_nxt      = active_r;
    wd_nxt          = wd_r;
    arm_nxt         = arm_r;
    age_nxt         = age_r;
    last_vote_nxt   = last_vote_r;
    last_ladder_nxt = last_ladder_r;
    exp_nxt         = 1'b0;
    slip_nxt        = 1'b0;
    reach_nxt       = 1'b0;
    dwell_nxt       = 1'b0;
    vote            = 1'b0;
    clear           = 1'b0;
    wd_tick         = wd_r || (cb_r != ca_r);
    start_active    = enable_r && (min_r != max_r);
    target_sum      = {1'b0, remembered_r} + {1'b0, step_r};

    case (cmd_r)
      CMD_START: begin
        clear           = 1'b1;
        active_nxt      = start_active;
        wd_nxt          = 1'b1;
        age_nxt         = '0;
        last_vote_nxt   = '0;
        last_ladder_nxt = '0;
        arm_nxt         = '0;
        if (start_active && (remembered_r >= min_r) && (remembered_r < max_r)) begin
          arm_nxt = (target_sum > {1'b0, max_r}) ? max_r : target_sum[KHZ_W-1:0];
        end
      end
      CMD_BURST: begin
        wd_nxt = 1'b1;
        if (cancel_r) begin
          arm_nxt = '0;
        end
      end
      CMD_TICK: begin
        if (active_r) begin
          wd_nxt = wd_tick;
          // one vote per rate publication, only from a clean window
          if (seq_r != last_vote_r) begin
            vote          = !wd_tick && !ff_r && (sig_r inside {SIG_SLACK, SIG_BUSY});
            last_vote_nxt = seq_r;
            wd_nxt        = 1'b0;
          end
          // arm ladder
          if (arm_r != '0) begin
            age_nxt = (age_r == ARM_AGE_MAX) ? age_r : age_r + AGE_W'(1);
            if (age_nxt > ARM_EXPIRY_TICKS) begin
              arm_nxt = '0;
              exp_nxt = 1'b1;
            end else if (ff_r) begin
              arm_nxt = arm_r;
            end else if (sig_r inside {SIG_SLIP, SIG_BIG_SLIP}) begin
              arm_nxt  = '0;
              slip_nxt = 1'b1;
            end else if (ca_r <= arm_r) begin
              arm_nxt   = '0;
              reach_nxt = 1'b1;
            end else if ((sig_r == SIG_SLACK) && (seq_r != last_ladder_r)) begin
              last_ladder_nxt = seq_r;
              dwell_nxt       = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign hist_req.go    = (state_r == S_EVAL);
  assign hist_req.clear = clear;
  assign hist_req.vote  = vote;
  assign hist_req.khz   = cb_r;

  dfmp_hist #(
    .HIST_SLOTS (HIST_SLOTS)
  ) u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (hist_req),
    .min_votes (min_votes_r),
    .rsp       (hist_rsp)
  );

  // sequencer and output register
  always_comb begin
    state_nxt = state_r;
    best_nxt  = best_r;
    load_out  = 1'b0;
    load_best = best_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (hist_rsp.done) begin
          best_nxt  = hist_rsp.best_khz;
          load_best = hist_rsp.best_khz;
          if (out_free) begin
            load_out  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_data_nxt  = load_out ? {load_best, arm_r, dwell_r, reach_r, slip_r, exp_r}
                             : out_data_r;
    out_valid_nxt = load_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      active_r      <= 1'b0;
      wd_r          <= 1'b1;
      arm_r         <= '0;
      age_r         <= '0;
      last_vote_r   <= '0;
      last_ladder_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_EVAL) begin
        active_r      <= active_nxt;
        wd_r          <= wd_nxt;
        arm_r         <= arm_nxt;
        age_r         <= age_nxt;
        last_vote_r   <= last_vote_nxt;
        last_ladder_r <= last_ladder_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_EVAL) begin
      exp_r   <= exp_nxt;
      slip_r  <= slip_nxt;
      reach_r <= reach_nxt;
      dwell_r <= dwell_nxt;
    end
    best_r     <= best_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `DFMP_ASSERT_NOW(a_done_in_walk, hist_rsp.done, state_r == S_WALK, "walk finished outside walk state")
  `DFMP_ASSERT_NOW(a_out_after_walk, $rose(out_valid_r), $past(state_r == S_WALK || state_r == S_DONE), "result without a finished walk")
  `DFMP_ASSERT_NEXT(a_accept_eval, in_xfer, state_r == S_EVAL && !in_tready, "accepted item not evaluated")
  `DFMP_ASSERT_NOW(a_age_bound, 1'b1, age_r <= ARM_AGE_LIMIT, "arm age beyond expiry bound")

endmodule

`default_nettype wire

### test/dvfs_floor_memory_policy_tb.sv
`timescale 1ns / 100ps

module dvfs_floor_memory_policy_tb;
  import dfmp_pkg::*;

  localparam int HIST_SLOTS     = 8;
  localparam int LATENCY        = HIST_SLOTS + 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [KHZ_W-1:0] KHZ_TOP = 22'h3F_FFFF;

  // codes the package leaves unnamed
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam logic [SIG_W-1:0] SIG_OTHER = 3'd0;
  localparam logic [SIG_W-1:0] SIG_SPARE = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [SIG_W-1:0] load_sig;
    logic             fast_fwd;
    logic [SEQ_W-1:0] pub_seq;
    logic [KHZ_W-1:0] ceil_prev;
    logic [KHZ_W-1:0] ceil_next;
    logic             drop_arm;
  } gov_event_t;

  typedef struct packed {
    logic             expired;
    logic             slip_disarmed;
    logic             target_reached;
    logic             preload_dwell;
    logic [KHZ_W-1:0] armed_khz;
    logic [KHZ_W-1:0] best_khz;
  } gov_result_t;

  logic                   clk;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_wr_en;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wr_data;

  // policy registers as the block should hold them
  logic             pol_enable;
  logic [KHZ_W-1:0] floor_khz;
  logic [KHZ_W-1:0] lo_khz;
  logic [KHZ_W-1:0] hi_khz;
  logic [KHZ_W-1:0] step_khz;
  logic [CNT_W-1:0] vote_quorum;

  // governor memory as the block should hold it
  logic             gov_active;
  logic             win_dirty;
  logic [KHZ_W-1:0] arm_khz;
  logic [AGE_W-1:0] arm_age_cnt;
  logic [SEQ_W-1:0] vote_seq_seen;
  logic [SEQ_W-1:0] ladder_seq_seen;
  logic [KHZ_W-1:0] slot_khz [HIST_SLOTS];
  logic [CNT_W-1:0] slot_votes [HIST_SLOTS];

  gov_result_t pending_results[$];

  int fail_count;
  int n_events, n_results, n_sessions, n_votes, n_dropped;
  int n_expired, n_slip, n_reach, n_dwell;
  int burst_left;
  int sink_run;
  bit sink_ready;
  bit send_gaps;
  bit sink_stalls;
  int quiet_cycles;

  dvfs_floor_memory_policy #(
    .HIST_SLOTS (HIST_SLOTS)
  ) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data)
  );

  always #4 clk = ~clk;

  // governor memory cleared by reset and by every start item
  function automatic void clear_governor();
    gov_active      = 1'b0;
    win_dirty       = 1'b1;
    arm_khz         = '0;
    arm_age_cnt     = '0;
    vote_seq_seen   = '0;
    ladder_seq_seen = '0;
    for (int i = 0; i < HIST_SLOTS; i++) begin
      slot_khz[i]   = '0;
      slot_votes[i] = '0;
    end
  endfunction

  // first slot holding the frequency or empty takes the vote
  function automatic void cast_vote(logic [KHZ_W-1:0] khz);
    for (int i = 0; i < HIST_SLOTS; i++) begin
      if (slot_votes[i] == '0 || slot_khz[i] == khz) begin
        slot_khz[i] = khz;
        if (slot_votes[i] != CNT_MAX) slot_votes[i] = slot_votes[i] + 1'b1;
        n_votes++;
        return;
      end
    end
    n_dropped++;
  endfunction

  // next governor result, advancing the expected memory
  function automatic gov_result_t predict_governor(gov_event_t ev);
    gov_result_t      r;
    logic [KHZ_W:0]   sum;
    logic [63:0]      total;
    logic [CNT_W-1:0] top_n;
    r = '0;
    if (ev.cmd == CMD_START) begin
      clear_governor();
      n_sessions++;
      gov_active = pol_enable && (lo_khz != hi_khz);
      if (gov_active && floor_khz >= lo_khz && floor_khz < hi_khz) begin
        sum = {1'b0, floor_khz} + {1'b0, step_khz};
        arm_khz = (sum > {1'b0, hi_khz}) ? hi_khz : sum[KHZ_W-1:0];
      end
    end else if (ev.cmd == CMD_BURST) begin
      win_dirty = 1'b1;
      if (ev.drop_arm) arm_khz = '0;
    end else if (ev.cmd == CMD_TICK && gov_active) begin
      if (ev.ceil_prev != ev.ceil_next) win_dirty = 1'b1;
      // one vote per rate publication, clean window only
      if (ev.pub_seq != vote_seq_seen) begin
        if (!win_dirty && !ev.fast_fwd && (ev.load_sig == SIG_SLACK || ev.load_sig == SIG_BUSY))
          cast_vote(ev.ceil_prev);
        vote_seq_seen = ev.pub_seq;
        win_dirty = 1'b0;
      end
      // arm ladder
      if (arm_khz != '0) begin
        if (arm_age_cnt != ARM_AGE_MAX) arm_age_cnt = arm_age_cnt + 1'b1;
        if (arm_age_cnt > ARM_EXPIRY_TICKS) begin
          arm_khz = '0;
          r.expired = 1'b1;
          n_expired++;
        end else if (!ev.fast_fwd) begin
          if (ev.load_sig == SIG_SLIP || ev.load_sig == SIG_BIG_SLIP) begin
            arm_khz = '0;
            r.slip_disarmed = 1'b1;
            n_slip++;
          end else if (ev.ceil_next <= arm_khz) begin
            arm_khz = '0;
            r.target_reached = 1'b1;
            n_reach++;
          end else if (ev.load_sig == SIG_SLACK && ev.pub_seq != ladder_seq_seen) begin
            ladder_seq_seen = ev.pub_seq;
            r.preload_dwell = 1'b1;
            n_dwell++;
          end
        end
      end
    end
    r.armed_khz = arm_khz;
    // most voted frequency, first slot wins a tie
    total = '0;
    top_n = '0;
    r.best_khz = '0;
    for (int i = 0; i < HIST_SLOTS; i++) begin
      total = total + slot_votes[i];
      if (slot_votes[i] > top_n) begin
        top_n = slot_votes[i];
        r.best_khz = slot_khz[i];
      end
    end
    if (total < {32'd0, vote_quorum}) r.best_khz = '0;
    return r;
  endfunction

  function automatic gov_event_t make_event(logic [CMD_W-1:0] cmd, logic [SIG_W-1:0] load_sig,
                                            logic fast_fwd, logic [SEQ_W-1:0] pub_seq,
                                            logic [KHZ_W-1:0] ceil_prev,
                                            logic [KHZ_W-1:0] ceil_next, logic drop_arm);
    gov_event_t ev;
    ev.cmd       = cmd;
    ev.load_sig  = load_sig;
    ev.fast_fwd  = fast_fwd;
    ev.pub_seq   = pub_seq;
    ev.ceil_prev = ceil_prev;
    ev.ceil_next = ceil_next;
    ev.drop_arm  = drop_arm;
    return ev;
  endfunction

  function automatic gov_event_t random_event();
    return make_event(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                      1'($urandom_range(0, 1)), $urandom,
                      22'($urandom_range(0, KHZ_TOP)), 22'($urandom_range(0, KHZ_TOP)),
                      1'($urandom_range(0, 1)));
  endfunction

  function automatic void check_field(string name, logic [KHZ_W-1:0] want,
                                      logic [KHZ_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // one input transfer, sender idles in bursts
  task automatic send_event(gov_event_t ev);
    int gap;
    if (send_gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 20);
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(1, 8);
      end
      burst_left--;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = ev.cmd;
    in_tdata  = {7'd0, ev.drop_arm, ev.ceil_next, ev.ceil_prev, ev.pub_seq,
                 ev.fast_fwd, ev.load_sig};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_events++;
    pending_results.push_back(predict_governor(ev));
  endtask

  task automatic send_tick(logic [SIG_W-1:0] load_sig, logic fast_fwd,
                           logic [SEQ_W-1:0] pub_seq, logic [KHZ_W-1:0] ceil_prev,
                           logic [KHZ_W-1:0] ceil_next);
    send_event(make_event(CMD_TICK, load_sig, fast_fwd, pub_seq, ceil_prev, ceil_next, 1'b0));
  endtask

  task automatic send_start();
    send_event(make_event(CMD_START, SIG_OTHER, 1'b0, '0, '0, '0, 1'b0));
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_addr    = idx;
    cfg_wr_data = val;
    @(posedge clk);
    case (idx)
      REG_ENABLE:     pol_enable  = val[0];
      REG_REMEMBERED: floor_khz   = val[KHZ_W-1:0];
      REG_MIN:        lo_khz      = val[KHZ_W-1:0];
      REG_MAX:        hi_khz      = val[KHZ_W-1:0];
      REG_STEP:       step_khz    = val[KHZ_W-1:0];
      REG_MIN_VOTES:  vote_quorum = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic program_policy(logic en, logic [KHZ_W-1:0] rem, logic [KHZ_W-1:0] lo,
                                logic [KHZ_W-1:0] hi, logic [KHZ_W-1:0] step,
                                logic [CNT_W-1:0] quorum);
    write_reg(REG_ENABLE, {31'd0, en});
    write_reg(REG_REMEMBERED, {10'd0, rem});
    write_reg(REG_MIN, {10'd0, lo});
    write_reg(REG_MAX, {10'd0, hi});
    write_reg(REG_STEP, {10'd0, step});
    write_reg(REG_MIN_VOTES, quorum);
  endtask

  // drop valid and wait until every result has come back
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // reset values, inactive policy, unused command
  task automatic test_reset_state();
    send_gaps   = 1'b0;
    sink_stalls = 1'b0;
    send_tick(SIG_SLACK, 1'b0, 32'd1, 22'd500000, 22'd500000);
    send_event(make_event(CMD_BURST, SIG_OTHER, 1'b0, '0, '0, '0, 1'b1));
    send_event(make_event(CMD_SPARE, SIG_SPARE, 1'b1, '1, KHZ_TOP, KHZ_TOP, 1'b1));
    send_start();
    send_tick(SIG_BUSY, 1'b0, 32'd2, 22'd500000, 22'd500000);
    settle();
  endtask

  // voting rules and the dwell, slip, reach and cancel ladder outcomes on a fixed profile
  task automatic test_directed_ladder();
    program_policy(1'b1, 22'd1500000, 22'd1000000, 22'd2000000, STEP_RESET, 32'd0);
    send_start();
    send_tick(SIG_SLACK, 1'b0, 32'd1, 22'd1800000, 22'd1800000);
    send_tick(SIG_SLACK, 1'b0, 32'd2, 22'd1800000, 22'd1800000);
    send_tick(SIG_SLACK, 1'b0, 32'd2, 22'd1800000, 22'd1800000);
    send_tick(SIG_BUSY, 1'b1, 32'd3, 22'd1800000, 22'd1800000);
    send_tick(SIG_BUSY, 1'b0, 32'd4, 22'd1900000, 22'd1700000);
    send_tick(SIG_SPARE, 1'b0, 32'd5, 22'd1800000, 22'd1800000);
    send_tick(SIG_BUSY, 1'b0, 32'd6, 22'd1800000, 22'd1800000);
    send_event(make_event(CMD_BURST, SIG_OTHER, 1'b0, '0, '0, '0, 1'b0));
    send_tick(SIG_BUSY, 1'b0, 32'd7, 22'd1800000, 22'd1800000);
    send_tick(SIG_SLACK, 1'b0, '1, KHZ_TOP, KHZ_TOP);
    send_event(make_event(CMD_BURST, SIG_OTHER, 1'b0, '0, '0, '0, 1'b1));
    send_start();
    send_tick(SIG_SLIP, 1'b0, 32'd1, 22'd1800000, 22'd1800000);
    send_start();
    send_tick(SIG_BIG_SLIP, 1'b0, 32'd1, 22'd1800000, 22'd1800000);
    send_start();
    send_tick(SIG_OTHER, 1'b0, 32'd1, '0, '0);
    settle();
  endtask

  // clamped target, out-of-range floor, quorum extreme, inactive profiles
  task automatic test_config_extremes();
    program_policy(1'b1, 22'd4194300, '0, KHZ_TOP, KHZ_TOP, 32'd0);
    send_start();
    send_tick(SIG_SLACK, 1'b0, 32'd1, KHZ_TOP, KHZ_TOP);
    send_tick(SIG_SLACK, 1'b0, 32'd2, KHZ_TOP, KHZ_TOP);
    settle();
    write_reg(REG_MIN_VOTES, '1);
    send_tick(SIG_BUSY, 1'b0, 32'd2, KHZ_TOP, KHZ_TOP);
    settle();
    write_reg(REG_MIN_VOTES, 32'd1);
    write_reg(REG_REMEMBERED, {10'd0, KHZ_TOP});
    send_start();
    send_tick(SIG_BUSY, 1'b0, 32'd9, 22'd3000000, 22'd3000000);
    send_tick(SIG_BUSY, 1'b0, 32'd10, 22'd3000000, 22'd3000000);
    settle();
    write_reg(REG_MAX, '0);
    send_start();
    send_tick(SIG_SLACK, 1'b0, 32'd1, '0, '0);
    settle();
    write_reg(REG_ENABLE, '0);
    write_reg(REG_MAX, {10'd0, KHZ_TOP});
    send_start();
    send_tick(SIG_SLACK, 1'b0, 32'd1, '0, '0);
    settle();
  endtask

  // random profiles, each a session of well-formed ticks with some noise
  task automatic test_random_sessions(int n_runs);
    int unsigned      lo, hi, rem, step, quorum;
    logic             en;
    logic [KHZ_W-1:0] pool [12];
    int               pool_n, n_items, roll;
    logic [SEQ_W-1:0] seq;
    logic [SIG_W-1:0] sig;
    logic [KHZ_W-1:0] cb, ca;
    for (int s = 0; s < n_runs; s++) begin
      send_gaps   = (s % 3) != 0;
      sink_stalls = (s % 4) != 1;
      en     = 1'b1;
      lo     = $urandom_range(0, 3000000);
      hi     = $urandom_range(lo + 1, KHZ_TOP);
      rem    = $urandom_range(lo, hi - 1);
      step   = $urandom_range(0, 400000);
      quorum = $urandom_range(0, 6);
      case (s % 5)
        1: begin
          rem  = hi - 1;
          step = $urandom_range(2000000, KHZ_TOP);
        end
        2: quorum = $urandom;
        3: if ($urandom_range(0, 1) == 0) en = 1'b0; else hi = lo;
        4: rem = $urandom_range(hi, KHZ_TOP);
        default: ;
      endcase
      program_policy(en, 22'(rem), 22'(lo), 22'(hi), 22'(step), quorum);
      pool_n = $urandom_range(3, 12);
      for (int i = 0; i < pool_n; i++) pool[i] = 22'($urandom_range(lo, hi));
      send_start();
      seq = $urandom;
      n_items = $urandom_range(20, 36);
      for (int k = 0; k < n_items; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          send_event(random_event());
        end else if (roll < 13) begin
          send_event(make_event(CMD_BURST, SIG_OTHER, 1'b0, seq, '0, '0,
                                1'($urandom_range(0, 1))));
        end else if (roll < 16) begin
          send_start();
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 85) seq = seq + 1'b1;
          else if (roll >= 93) seq = $urandom;
          roll = $urandom_range(0, 99);
          if (roll < 70) sig = ($urandom_range(0, 1) == 0) ? SIG_SLACK : SIG_BUSY;
          else if (roll < 94) sig = ($urandom_range(0, 3) == 0) ? SIG_OTHER
                                                                 : 3'($urandom_range(5, 7));
          else sig = ($urandom_range(0, 1) == 0) ? SIG_SLIP : SIG_BIG_SLIP;
          cb = pool[$urandom_range(0, pool_n - 1)];
          ca = ($urandom_range(0, 9) == 0) ? pool[$urandom_range(0, pool_n - 1)] : cb;
          send_tick(sig, 1'($urandom_range(0, 9) == 0), seq, cb, ca);
        end
      end
      settle();
    end
  endtask

  // a ceiling held above the target until the ladder runs out
  task automatic test_arm_expiry(int n_ticks);
    logic [KHZ_W-1:0] pool [5];
    logic [SEQ_W-1:0] seq;
    logic [SIG_W-1:0] sig;
    logic [KHZ_W-1:0] cb, ca;
    int               roll;
    send_gaps   = 1'b1;
    sink_stalls = 1'b1;
    program_policy(1'b1, 22'd1000000, 22'd200000, 22'd3000000, 22'd100000, 32'd3);
    for (int i = 0; i < 5; i++) pool[i] = 22'($urandom_range(1100001, KHZ_TOP));
    send_start();
    seq = $urandom;
    for (int k = 0; k < n_ticks; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        send_event(make_event(CMD_BURST, SIG_OTHER, 1'b0, seq, '0, '0, 1'b0));
      end else begin
        if (roll < 90) seq = seq + 1'b1;
        roll = $urandom_range(0, 9);
        if (roll < 4) sig = SIG_SLACK;
        else if (roll < 8) sig = SIG_BUSY;
        else sig = ($urandom_range(0, 1) == 0) ? SIG_OTHER : 3'($urandom_range(5, 7));
        cb = pool[$urandom_range(0, 4)];
        ca = ($urandom_range(0, 9) == 0) ? pool[$urandom_range(0, 4)] : cb;
        send_tick(sig, 1'($urandom_range(0, 4) == 0), seq, cb, ca);
      end
    end
    settle();
  endtask

  // receiver alternates ready and stall runs of random length
  always @(negedge clk) begin
    if (!sink_stalls) begin
      out_tready = 1'b1;
    end else begin
      if (sink_run == 0) begin
        sink_ready = !sink_ready;
        sink_run = sink_ready ? $urandom_range(1, 10) : $urandom_range(1, 16);
      end
      sink_run--;
      out_tready = sink_ready;
    end
  end

  // each result transfer against the oldest expectation
  always @(posedge clk) begin : result_check
    gov_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing outstanding: %h", out_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("expired", want.expired, out_tdata[0]);
        check_field("slip_disarmed", want.slip_disarmed, out_tdata[1]);
        check_field("target_reached", want.target_reached, out_tdata[2]);
        check_field("preload_dwell", want.preload_dwell, out_tdata[3]);
        check_field("armed_khz", want.armed_khz, out_tdata[25:4]);
        check_field("best_khz", want.best_khz, out_tdata[47:26]);
      end
    end
  end

  // watchdog on cycles without any transfer or register write
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    in_tvalid   = 1'b0;
    out_tready  = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_addr    = '0;
    cfg_wr_data = '0;
    send_gaps   = 1'b0;
    sink_stalls = 1'b0;
    sink_run    = 0;
    sink_ready  = 1'b0;
    burst_left  = 0;
    fail_count  = 0;
    n_events    = 0;
    n_results   = 0;
    n_sessions  = 0;
    n_votes     = 0;
    n_dropped   = 0;
    n_expired   = 0;
    n_slip      = 0;
    n_reach     = 0;
    n_dwell     = 0;
    pol_enable  = 1'b0;
    floor_khz   = '0;
    lo_khz      = '0;
    hi_khz      = '0;
    step_khz    = STEP_RESET;
    vote_quorum = '0;
    clear_governor();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_directed_ladder();
    test_config_extremes();
    test_random_sessions(10);
    test_arm_expiry(260);

    // catch any stray result after the last expected one
    repeat (2 * LATENCY) @(posedge clk);

    $display("%0d events sent, %0d results checked over %0d sessions", n_events, n_results,
             n_sessions);
    $display("votes %0d (dropped %0d), dwell %0d, reached %0d, slip %0d, expired %0d",
             n_votes, n_dropped, n_dwell, n_reach, n_slip, n_expired);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
